// File: rtl/stda_pkg.sv
// Package with shared constants and types for the sighting table.
package stda_pkg;

    localparam int TableDepthDefault = 512;
    localparam logic [7:0] MatchWindowReset = 8'd2;

    localparam logic [1:0] OpAdd   = 2'd0;
    localparam logic [1:0] OpRead  = 2'd1;
    localparam logic [1:0] OpClear = 2'd2;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StFull  = 2'd1;
    localparam logic [1:0] StInval = 2'd2;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [8:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [7:0]  quotient;
    } t_div_rsp;

endpackage

// File: rtl/stda_div.sv
// Iterative divider of a signed dividend by an unsigned divisor, one quotient bit per cycle, truncating toward zero.
module stda_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stda_pkg::t_div_req i_req,
    output stda_pkg::t_div_rsp o_rsp
);

    logic [15:0] r_num;
    logic [16:0] r_rem;
    logic [8:0]  r_den;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] n_rem;
    logic [16:0] w_try;
    logic [15:0] w_abs;
    logic [15:0] w_q;

    assign w_abs = i_req.dividend[15] ? (~i_req.dividend + 16'd1) : i_req.dividend;
    assign n_rem = {r_rem[15:0], r_num[15]};
    assign w_try = n_rem - {8'd0, r_den};
    assign w_q   = r_neg ? (~r_num + 16'd1) : r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_num  <= w_abs;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
                r_neg  <= i_req.dividend[15];
                r_cnt  <= 5'd16;
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                if (w_try[16]) begin
                    r_rem <= n_rem;
                    r_num <= {r_num[14:0], 1'b0};
                end else begin
                    r_rem <= w_try;
                    r_num <= {r_num[14:0], 1'b1};
                end
                r_cnt  <= r_cnt - 5'd1;
                r_done <= (r_cnt == 5'd1);
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = w_q[7:0];

endmodule

// File: rtl/sighting_table_dedup_average.sv
// Top level of the sighting table with duplicate merging and strength averaging.
// Usage: one command transfer on the s_axis group returns exactly one result
// transfer on the m_axis group. An add searches held entries newest first,
// one entry at a time through a single memory read port, stopping at a match,
// at the first entry older than the match window or after all held entries,
// then merges through a serial divider or appends (status full if the table
// is full). Each entry checked takes states S_RD and S_CHK; a merge then
// goes through S_DIV and S_WB, and every result through S_OUT. A read takes
// S_RD and S_CHK; a clear, a rejected read or an unknown opcode go to S_OUT.
// s_axis_tready is high only while the block is idle, and stays low until the
// result is taken, so a stalled receiver holds the block; the next command can
// be taken in the cycle after the result transfer. Reset empties the table,
// sets the match window to 2, and clears the control state; table memories are
// not cleared, since only written entries are ever read. The configuration
// channel writes the match window and is taken in any cycle, only while idle
// by contract.
module sighting_table_dedup_average #(
    parameter int TABLE_DEPTH = stda_pkg::TableDepthDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[1:0], rpi_high[65:2], rpi_low[129:66], aem[161:130], rssi[169:162],
    // interval[201:170], index[210:202], zero pad.
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], out_rpi_high[65:2], out_rpi_low[129:66], out_aem[161:130],
    // out_rssi[169:162], sighting_count[177:170], last_interval[209:178],
    // entries_held[219:210], zero pad.
    output logic [223:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CHK, S_DIV, S_WB, S_OUT
    } t_state;

    logic [63:0] r_mem_hi  [TABLE_DEPTH];
    logic [63:0] r_mem_lo  [TABLE_DEPTH];
    logic [31:0] r_mem_aem [TABLE_DEPTH];
    logic [7:0]  r_mem_rs  [TABLE_DEPTH];
    logic [7:0]  r_mem_cnt [TABLE_DEPTH];
    logic [31:0] r_mem_iv  [TABLE_DEPTH];

    t_state      r_state;
    logic [7:0]  r_window;
    logic [AW-1:0] r_wp;
    logic [FW-1:0] r_fill;
    logic [1:0]  r_op;
    logic [63:0] r_hi, r_lo;
    logic [31:0] r_aem, r_iv;
    logic [7:0]  r_rssi;
    logic [AW-1:0] r_addr;
    logic [FW-1:0] r_i;
    logic [63:0] r_q_hi, r_q_lo;
    logic [31:0] r_q_aem, r_q_iv;
    logic [7:0]  r_q_rs, r_q_cnt;
    logic [7:0]  r_newc;
    logic        r_we;
    logic [AW-1:0] r_wa;
    logic        r_we_new;
    logic [7:0]  r_wrs, r_wcnt;
    logic [223:0] r_out;
    logic        r_oval;

    stda_pkg::t_div_req w_dreq;
    stda_pkg::t_div_rsp w_drsp;
    logic [15:0] r_sum;
    logic        r_dstart;

    logic [31:0] w_age;
    logic [FW-1:0] w_fill1;
    logic [AW:0] w_rsum;
    logic [AW-1:0] w_rslot;
    logic [AW-1:0] w_prev_wp;
    logic [AW-1:0] w_next_wp;
    logic [AW-1:0] w_prev_addr;
    logic        w_rd_bad;

    stda_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    assign w_dreq.start    = r_dstart;
    assign w_dreq.dividend = r_sum;
    assign w_dreq.divisor  = {1'b0, r_newc};

    assign w_age   = r_iv - r_q_iv;
    assign w_fill1 = r_fill + FW'(1);
    assign w_rsum  = {1'b0, r_wp} + DEPTH_W - (AW + 1)'(r_fill)
                   + (AW + 1)'(s_axis_tdata[210:202]);
    assign w_rslot = (w_rsum >= DEPTH_W) ? AW'(w_rsum - DEPTH_W) : AW'(w_rsum);
    assign w_prev_wp   = (r_wp == '0) ? LAST_SLOT : r_wp - AW'(1);
    assign w_next_wp   = (r_wp == LAST_SLOT) ? '0 : r_wp + AW'(1);
    assign w_prev_addr = (r_addr == '0) ? LAST_SLOT : r_addr - AW'(1);
    assign w_rd_bad    = 32'(s_axis_tdata[210:202]) >= 32'(r_fill);

    assign s_axis_tready = (r_state == S_IDLE) && !r_oval;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem_rs[r_wa]  <= r_wrs;
            r_mem_cnt[r_wa] <= r_wcnt;
            r_mem_iv[r_wa]  <= r_iv;
            if (r_we_new) begin
                r_mem_hi[r_wa]  <= r_hi;
                r_mem_lo[r_wa]  <= r_lo;
                r_mem_aem[r_wa] <= r_aem;
            end
        end
        r_q_hi  <= r_mem_hi[r_addr];
        r_q_lo  <= r_mem_lo[r_addr];
        r_q_aem <= r_mem_aem[r_addr];
        r_q_rs  <= r_mem_rs[r_addr];
        r_q_cnt <= r_mem_cnt[r_addr];
        r_q_iv  <= r_mem_iv[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_window <= stda_pkg::MatchWindowReset;
            r_wp     <= '0;
            r_fill   <= '0;
            r_oval   <= 1'b0;
            r_we     <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
            if (r_oval && m_axis_tready) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op   <= s_axis_tdata[1:0];
                        r_hi   <= s_axis_tdata[65:2];
                        r_lo   <= s_axis_tdata[129:66];
                        r_aem  <= s_axis_tdata[161:130];
                        r_rssi <= s_axis_tdata[169:162];
                        r_iv   <= s_axis_tdata[201:170];
                        r_i    <= '0;
                        if (s_axis_tdata[1:0] == stda_pkg::OpRead) begin
                            if (w_rd_bad) begin
                                r_out <= {4'd0, 10'(r_fill), 208'd0, stda_pkg::StInval};
                                r_state <= S_OUT;
                            end else begin
                                r_addr  <= w_rslot;
                                r_state <= S_RD;
                            end
                        end else if (s_axis_tdata[1:0] == stda_pkg::OpClear) begin
                            r_wp   <= '0;
                            r_fill <= '0;
                            r_out  <= {4'd0, 10'd0, 208'd0, stda_pkg::StOk};
                            r_state <= S_OUT;
                        end else if (s_axis_tdata[1:0] == stda_pkg::OpAdd) begin
                            r_addr  <= w_prev_wp;
                            r_state <= S_RD;
                        end else begin
                            r_out <= {4'd0, 10'(r_fill), 208'd0, stda_pkg::StInval};
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_op == stda_pkg::OpRead) begin
                        r_out <= {4'd0, 10'(r_fill), r_q_iv, r_q_cnt, r_q_rs,
                                  r_q_aem, r_q_lo, r_q_hi, stda_pkg::StOk};
                        r_state <= S_OUT;
                    end else if (r_i == r_fill || w_age > {24'd0, r_window}) begin
                        if (r_fill >= FW'(TABLE_DEPTH)) begin
                            r_out <= {4'd0, 10'(r_fill), 208'd0, stda_pkg::StFull};
                        end else begin
                            r_we     <= 1'b1;
                            r_we_new <= 1'b1;
                            r_wa     <= r_wp;
                            r_wrs    <= r_rssi;
                            r_wcnt   <= 8'd1;
                            r_wp     <= w_next_wp;
                            r_fill   <= w_fill1;
                            r_out <= {4'd0, 10'(w_fill1), 208'd0, stda_pkg::StOk};
                        end
                        r_state <= S_OUT;
                    end else if (r_q_hi == r_hi && r_q_lo == r_lo) begin
                        r_newc   <= (r_q_cnt == 8'd255) ? 8'd255 : r_q_cnt + 8'd1;
                        r_sum    <= 16'($signed(r_q_rs) * $signed({1'b0, r_q_cnt}))
                                  + {{8{r_rssi[7]}}, r_rssi};
                        r_dstart <= 1'b1;
                        r_state  <= S_DIV;
                    end else begin
                        r_i    <= r_i + FW'(1);
                        r_addr <= w_prev_addr;
                        r_state <= S_RD;
                    end
                end
                S_DIV: begin
                    r_dstart <= 1'b0;
                    if (w_drsp.done) begin
                        r_we     <= 1'b1;
                        r_we_new <= 1'b0;
                        r_wa     <= r_addr;
                        r_wrs    <= w_drsp.quotient;
                        r_wcnt   <= r_newc;
                        r_out <= {4'd0, 10'(r_fill), 208'd0, stda_pkg::StOk};
                        r_state  <= S_WB;
                    end
                end
                S_WB: begin
                    r_we    <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_we    <= 1'b0;
                    r_oval  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fill_le_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(TABLE_DEPTH))
        else $error("fill level exceeds table depth");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("command taken while busy");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside merge");
`endif

endmodule
